// File: sv/poskeep_pkg.sv
// ----------------------------------------------------------------------------
// poskeep_pkg
// Shared types, codes and helpers for the position keeper with limit check.
// ----------------------------------------------------------------------------
package poskeep_pkg;

  localparam int QtyW   = 47;   // unsigned quantity / limit, 8 fraction bits
  localparam int PosW   = 48;   // signed position and leg totals
  localparam int IdW    = 32;
  localparam int SumW   = 50;   // headroom for three-operand compares
  localparam int CfgIdxW = 1;

  localparam int InDataW  = 184; // 179 payload bits padded to whole bytes
  localparam int OutDataW = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TRADE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SIDE_BUY  = 2'd0,
    SIDE_SELL = 2'd1,
    SIDE_UNK  = 2'd2,
    SIDE_UNK3 = 2'd3
  } side_t;

  typedef enum logic [1:0] {
    EFF_OPEN  = 2'd0,
    EFF_CLOSE = 2'd1,
    EFF_OVER  = 2'd2
  } effect_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DUP     = 2'd2
  } status_t;

  localparam logic [CfgIdxW-1:0] REG_LONG_LIMIT  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_LIMIT = 1'd1;

  typedef struct packed {
    logic signed [PosW-1:0] start;
    logic signed [PosW-1:0] opened;
    logic signed [PosW-1:0] closed;
    logic [IdW-1:0]         last_id;
    logic [IdW-1:0]         max_id;
  } leg_t;

  typedef struct packed {
    cmd_t                   command;
    side_t                  side;
    logic                   is_close;
    logic                   in_download;
    logic [QtyW-1:0]        quantity;
    logic signed [PosW-1:0] position;
    logic signed [PosW-1:0] prior_position;
    logic [IdW-1:0]         txn_id;
  } item_t;

  typedef struct packed {
    status_t status;
    effect_t effect;
  } result_t;

  // Clamp a 49-bit signed sum into the 48-bit signed range.
  function automatic logic signed [PosW-1:0] sat48(input logic signed [PosW:0] v);
    logic signed [PosW-1:0] r;
    if (v[PosW] != v[PosW-1]) begin
      r = v[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/position_keeper_with_limit_check_top.sv
// ----------------------------------------------------------------------------
// position_keeper_with_limit_check_top
// Long/short position keeper: clear, position load, trade and limit query.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side is not stalled and returns
// exactly one result item per input item. Items pass an input register, one
// combinational update of the two legs, and a result register; leg state is
// written in the same cycle the item is evaluated, so the following item
// already sees it. Limits are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while no item is in flight, the block does not enforce it.
module position_keeper_with_limit_check_top
  import poskeep_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // side[1:0], is_close[2], in_download[3], quantity[50:4],
  // position[98:51], prior_position[146:99], txn_id[178:147], zero pad
  input  logic [InDataW-1:0]  s_tdata,
  // command[1:0]
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // effect[1:0], status[3:2], zero pad
  output logic [OutDataW-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [QtyW-1:0]     cfg_data
);

  logic            in_valid;
  item_t           in_item;
  logic            out_valid;
  result_t         out_res;
  logic            advance;
  logic            fire;

  logic [QtyW-1:0] lim_long;
  logic [QtyW-1:0] lim_short;
  leg_t            long_leg, long_leg_next;
  leg_t            short_leg, short_leg_next;
  result_t         res_next;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW-4){1'b0}}, out_res.status, out_res.effect};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_item.command        <= cmd_t'(s_tuser);
      in_item.side           <= side_t'(s_tdata[1:0]);
      in_item.is_close       <= s_tdata[2];
      in_item.in_download    <= s_tdata[3];
      in_item.quantity       <= s_tdata[50:4];
      in_item.position       <= s_tdata[98:51];
      in_item.prior_position <= s_tdata[146:99];
      in_item.txn_id         <= s_tdata[178:147];
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_long  <= '0;
      lim_short <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_LIMIT:  lim_long  <= cfg_data;
        REG_SHORT_LIMIT: lim_short <= cfg_data;
        default: ;
      endcase
    end
  end

  // Query datapath: pick own and opposite leg by order side
  logic                   side_known;
  logic                   side_buy;
  leg_t                   q_own, q_other;
  logic [QtyW-1:0]        q_limit;
  logic signed [SumW-1:0] close_sum;
  logic signed [SumW-1:0] limit_sum;
  effect_t                q_effect;

  assign side_known = (in_item.side == SIDE_BUY) || (in_item.side == SIDE_SELL);
  assign side_buy   = (in_item.side == SIDE_BUY);

  always_comb begin
    q_own   = side_buy ? long_leg  : short_leg;
    q_other = side_buy ? short_leg : long_leg;
    q_limit = side_buy ? lim_long : lim_short;
    close_sum = $signed({{(SumW-QtyW){1'b0}}, in_item.quantity})
              + {{(SumW-PosW){q_other.closed[PosW-1]}}, q_other.closed}
              - {{(SumW-PosW){q_other.start[PosW-1]}}, q_other.start};
    limit_sum = {{(SumW-PosW){q_own.opened[PosW-1]}}, q_own.opened}
              + $signed({{(SumW-QtyW){1'b0}}, in_item.quantity})
              - $signed({{(SumW-QtyW){1'b0}}, q_limit});
    if (close_sum[SumW-1] || (close_sum == '0)) begin
      q_effect = EFF_CLOSE;
    end else if (!limit_sum[SumW-1] && (limit_sum != '0)) begin
      q_effect = EFF_OVER;
    end else begin
      q_effect = EFF_OPEN;
    end
  end

  // Trade datapath: buy-open and sell-close hit the long leg
  logic                   tgt_long;
  leg_t                   tgt;
  leg_t                   trade_leg;
  logic [IdW-1:0]         ref_id;
  logic                   trade_new;
  logic signed [PosW-1:0] tot;
  logic signed [PosW:0]   tot_sum;
  logic signed [PosW-1:0] tot_sat;

  always_comb begin
    tgt_long  = side_buy ^ in_item.is_close;
    tgt       = tgt_long ? long_leg : short_leg;
    ref_id    = in_item.in_download ? tgt.last_id : tgt.max_id;
    trade_new = in_item.txn_id > ref_id;
    tot       = in_item.is_close ? tgt.closed : tgt.opened;
    tot_sum   = {tot[PosW-1], tot} + $signed({2'b00, in_item.quantity});
    tot_sat   = sat48(tot_sum);
    trade_leg = tgt;
    if (in_item.is_close) begin
      trade_leg.closed = tot_sat;
    end else begin
      trade_leg.opened = tot_sat;
    end
    if (in_item.txn_id > tgt.max_id) begin
      trade_leg.max_id = in_item.txn_id;
    end
  end

  // Position load datapath
  leg_t                 load_leg;
  logic                 load_ok;
  logic signed [PosW:0] load_diff;

  always_comb begin
    load_diff = {in_item.position[PosW-1], in_item.position}
              - {in_item.prior_position[PosW-1], in_item.prior_position};
    load_ok   = in_item.in_download && !in_item.position[PosW-1] && side_known;
    load_leg  = side_buy ? long_leg : short_leg;
    load_leg.start   = in_item.prior_position;
    load_leg.opened  = sat48(load_diff);
    load_leg.last_id = in_item.txn_id;
    load_leg.max_id  = in_item.txn_id;
  end

  // Command decode and state update
  always_comb begin
    long_leg_next   = long_leg;
    short_leg_next  = short_leg;
    res_next.effect = EFF_OPEN;
    res_next.status = ST_APPLIED;
    unique case (in_item.command)
      CMD_CLEAR: begin
        long_leg_next  = '0;
        short_leg_next = '0;
      end
      CMD_LOAD: begin
        if (!load_ok) begin
          res_next.status = ST_IGNORED;
        end else if (side_buy) begin
          long_leg_next = load_leg;
        end else begin
          short_leg_next = load_leg;
        end
      end
      CMD_TRADE: begin
        if (!side_known) begin
          res_next.status = ST_IGNORED;
        end else if (!trade_new) begin
          res_next.status = ST_DUP;
        end else if (tgt_long) begin
          long_leg_next = trade_leg;
        end else begin
          short_leg_next = trade_leg;
        end
      end
      CMD_QUERY: begin
        if (!side_known) begin
          res_next.effect = EFF_OVER;
          res_next.status = ST_IGNORED;
        end else begin
          res_next.effect = q_effect;
        end
      end
      default: ;
    endcase
  end

  // Leg state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_leg  <= '0;
      short_leg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        long_leg  <= long_leg_next;
        short_leg <= short_leg_next;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
    if (fire) begin
      out_res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.command == CMD_CLEAR) |=> (long_leg == '0) && (short_leg == '0))
    else $error("legs not cleared after clear item");

  a_nonquery_effect: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.command != CMD_QUERY) |=> out_valid && (out_res.effect == EFF_OPEN))
    else $error("non-query item produced a nonzero effect");

  a_unknown_query: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.command == CMD_QUERY) && !side_known
    |=> (out_res.effect == EFF_OVER) && (out_res.status == ST_IGNORED))
    else $error("unknown-side query not refused");

  a_trade_maxid: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.command == CMD_TRADE)
    |=> (long_leg.max_id >= $past(long_leg.max_id))
        && (short_leg.max_id >= $past(short_leg.max_id)))
    else $error("trade lowered a highest trade id");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(long_leg) && $stable(short_leg))
    else $error("leg state changed without an item");
`endif

endmodule
